>>> rtl/lkhc_pkg.sv
// ----------------------------------------------------------------------------
// lkhc_pkg
// Shared constants, types and codes for the keyed handle cache: entry
// layout, cell control group, command and register codes, state encoding.
// ----------------------------------------------------------------------------
package lkhc_pkg;

  // geometry
  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 64;
  localparam int HANDLE_W   = 64;
  localparam int FIELD_W    = 64;
  localparam int COUNT_W    = 32;
  localparam int CAP_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // request commands
  typedef enum logic {
    CMD_ACQUIRE = 1'b0,
    CMD_CLEAR   = 1'b1
  } command_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLED  = 1'b0,
    REG_CAPACITY = 1'b1
  } reg_index_t;

  // sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  // what every cell does in the update cycle
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_HIT,
    CELL_INSERT,
    CELL_EVICT
  } cell_op_t;

  // one cached entry
  typedef struct packed {
    logic [KEY_BITS-1:0] layout;
    logic [KEY_BITS-1:0] hash;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  // control broadcast to the row of cells
  typedef struct packed {
    logic     compare;
    cell_op_t op;
    logic     evict;
  } cell_ctrl_t;

endpackage

>>> rtl/lru_keyed_handle_cache_top.sv
// ----------------------------------------------------------------------------
// lru_keyed_handle_cache_top
// Flow: key compare registered at acceptance; chain update and result register
// follow in the ST_UPDATE state.
// A new request is stalled during ST_UPDATE and while out_stall holds a result.
// Reset: table empty, counters zero, disabled, capacity 16; no clearing pass.
// Fully associative handle cache kept as a row of cells ordered by recency:
// the front cell is most recent, the last valid cell is the eviction victim.
// ----------------------------------------------------------------------------
module lru_keyed_handle_cache_top import lkhc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  command,
  input  logic [FIELD_W-1:0]    layout,
  input  logic [FIELD_W-1:0]    binding_hash,
  input  logic [HANDLE_W-1:0]   new_handle,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [HANDLE_W-1:0]   handle,
  output logic                  hit,
  output logic                  evicted,
  output logic [HANDLE_W-1:0]   evicted_handle,
  output logic [COUNT_W-1:0]    hit_count,
  output logic [COUNT_W-1:0]    miss_count
);

  state_t              state, state_next;
  cell_ctrl_t          ctrl;
  logic                accept;

  logic                enabled;
  logic [CAP_W-1:0]    capacity;
  logic [IDX_W-1:0]    cap_idx;

  logic                req_command;
  logic [KEY_BITS-1:0] req_layout;
  logic [KEY_BITS-1:0] req_hash;
  logic [HANDLE_W-1:0] req_new_handle;

  logic [COUNT_W-1:0]  hits_total, hits_total_next;
  logic [COUNT_W-1:0]  misses_total, misses_total_next;

  entry_t              cell_entry [ENTRIES];
  logic [ENTRIES-1:0]  cell_valid;
  logic [ENTRIES-1:0]  cell_gone;
  logic [ENTRIES-1:0]  cell_seen;
  logic [HANDLE_W-1:0] cell_hit_handle [ENTRIES];
  logic [HANDLE_W-1:0] cell_evict_handle [ENTRIES];

  logic                is_clear;
  logic                is_acquire;
  logic                hit_any;
  logic                do_evict;
  logic [HANDLE_W-1:0] hit_handle_any;
  logic [HANDLE_W-1:0] evict_handle_any;
  entry_t              front_entry;

  logic [HANDLE_W-1:0] handle_next;
  logic [HANDLE_W-1:0] evicted_handle_next;
  logic                out_valid_next;

  assign accept = in_valid & ~in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled  <= 1'b0;
      capacity <= CAP_W'(16);
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_ENABLED:  enabled  <= cfg_data[0];
        REG_CAPACITY: capacity <= cfg_data;
        default: ;
      endcase
    end
  end

  // capacity clamped to 1..ENTRIES, as the index of the last cell in use
  always_comb begin
    if (capacity == '0) begin
      cap_idx = '0;
    end else if (32'(capacity) > 32'(ENTRIES)) begin
      cap_idx = IDX_W'(ENTRIES - 1);
    end else begin
      cap_idx = IDX_W'(capacity - CAP_W'(1));
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_command    <= command;
      req_layout     <= layout[KEY_BITS-1:0];
      req_hash       <= binding_hash[KEY_BITS-1:0];
      req_new_handle <= new_handle;
    end
  end

  // reductions across the row
  always_comb begin
    hit_handle_any   = '0;
    evict_handle_any = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_handle_any   = hit_handle_any | cell_hit_handle[i];
      evict_handle_any = evict_handle_any | cell_evict_handle[i];
    end
  end

  assign is_clear   = (req_command == CMD_CLEAR);
  assign is_acquire = ~is_clear & enabled;
  assign hit_any    = cell_seen[ENTRIES-1];
  assign do_evict   = is_acquire & ~hit_any & cell_valid[cap_idx];

  // entry entering the front of the chain
  always_comb begin
    front_entry.layout = req_layout;
    front_entry.hash   = req_hash;
    front_entry.handle = hit_any ? hit_handle_any : req_new_handle;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // state outputs: handshake and cell control
  always_comb begin
    in_stall     = (state != ST_IDLE) | (out_valid & out_stall);
    ctrl.compare = 1'b0;
    ctrl.op      = CELL_HOLD;
    ctrl.evict   = 1'b0;
    case (state)
      ST_IDLE: begin
        ctrl.compare = in_valid & ~in_stall;
      end
      ST_UPDATE: begin
        ctrl.evict = do_evict;
        if (is_clear) begin
          ctrl.op = CELL_CLEAR;
        end else if (!enabled) begin
          ctrl.op = CELL_HOLD;
        end else if (hit_any) begin
          ctrl.op = CELL_HIT;
        end else if (req_new_handle != '0) begin
          ctrl.op = CELL_INSERT;
        end else begin
          ctrl.op = CELL_EVICT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // the row of cells
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    entry_t prev_entry;
    logic   prev_valid;
    logic   prev_gone;
    logic   prev_seen;
    logic   next_valid;

    if (i == 0) begin : g_front
      assign prev_entry = front_entry;
      assign prev_valid = 1'b1;
      assign prev_gone  = 1'b0;
      assign prev_seen  = 1'b0;
    end else begin : g_inner
      assign prev_entry = cell_entry[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_gone  = cell_gone[i-1];
      assign prev_seen  = cell_seen[i-1];
    end

    if (i == ENTRIES - 1) begin : g_tail
      assign next_valid = 1'b0;
    end else begin : g_body
      assign next_valid = cell_valid[i+1];
    end

    lkhc_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .key_layout   (layout[KEY_BITS-1:0]),
      .key_hash     (binding_hash[KEY_BITS-1:0]),
      .prev_entry   (prev_entry),
      .prev_valid   (prev_valid),
      .prev_gone    (prev_gone),
      .prev_seen    (prev_seen),
      .next_valid   (next_valid),
      .entry        (cell_entry[i]),
      .valid        (cell_valid[i]),
      .gone         (cell_gone[i]),
      .seen         (cell_seen[i]),
      .hit_handle   (cell_hit_handle[i]),
      .evict_handle (cell_evict_handle[i])
    );
  end

  // result and counter values
  always_comb begin
    hits_total_next     = hits_total;
    misses_total_next   = misses_total;
    handle_next         = '0;
    evicted_handle_next = '0;
    if (is_clear) begin
      hits_total_next   = '0;
      misses_total_next = '0;
    end else if (enabled) begin
      if (hit_any) begin
        hits_total_next = hits_total + COUNT_W'(1);
        handle_next     = hit_handle_any;
      end else begin
        misses_total_next = misses_total + COUNT_W'(1);
        handle_next       = req_new_handle;
        if (do_evict) evicted_handle_next = evict_handle_any;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hits_total   <= '0;
      misses_total <= '0;
    end else if (state == ST_UPDATE) begin
      hits_total   <= hits_total_next;
      misses_total <= misses_total_next;
    end
  end

  // output register
  always_comb begin
    out_valid_next = out_valid & out_stall;
    if (state == ST_UPDATE) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      handle         <= handle_next;
      hit            <= is_acquire & hit_any;
      evicted        <= do_evict;
      evicted_handle <= evicted_handle_next;
      hit_count      <= hits_total_next;
      miss_count     <= misses_total_next;
    end
  end

endmodule

>>> rtl/lkhc_cell.sv
// ----------------------------------------------------------------------------
// lkhc_cell
// One position of the recency chain. Position in the row is the recency
// rank; the cell compares its key, and on update takes its left neighbour's
// entry when the chain shifts.
// ----------------------------------------------------------------------------
module lkhc_cell import lkhc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cell_ctrl_t          ctrl,
  input  logic [KEY_BITS-1:0] key_layout,
  input  logic [KEY_BITS-1:0] key_hash,
  input  entry_t              prev_entry,
  input  logic                prev_valid,
  input  logic                prev_gone,
  input  logic                prev_seen,
  input  logic                next_valid,
  output entry_t              entry,
  output logic                valid,
  output logic                gone,
  output logic                seen,
  output logic [HANDLE_W-1:0] hit_handle,
  output logic [HANDLE_W-1:0] evict_handle
);

  logic match;

  // chain outputs: match seen so far, evicted tail, gated handles
  assign seen         = prev_seen | match;
  assign gone         = ctrl.evict & valid & ~next_valid;
  assign hit_handle   = match ? entry.handle : '0;
  assign evict_handle = gone ? entry.handle : '0;

  // valid bit and key match
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctrl.compare) begin
        match <= valid && (entry.layout == key_layout) && (entry.hash == key_hash);
      end
      case (ctrl.op)
        CELL_CLEAR:  valid <= 1'b0;
        CELL_HIT:    if (!prev_seen) valid <= prev_valid;
        CELL_INSERT: valid <= prev_valid & ~prev_gone;
        CELL_EVICT:  if (gone) valid <= 1'b0;
        default: ;
      endcase
    end
  end

  // entry payload shifts in from the left neighbour
  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_HIT:    if (!prev_seen) entry <= prev_entry;
      CELL_INSERT: entry <= prev_entry;
      default: ;
    endcase
  end

endmodule

>>> rtl/lkhc_checker.sv
// ----------------------------------------------------------------------------
// lkhc_checker
// Port-level checks on the keyed handle cache, attached to the top level.
// ----------------------------------------------------------------------------
module lkhc_checker import lkhc_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [HANDLE_W-1:0]   handle,
  input logic                  hit,
  input logic                  evicted,
  input logic [HANDLE_W-1:0]   evicted_handle,
  input logic [COUNT_W-1:0]    hit_count
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(handle) && $stable(hit_count))
    else $error("stalled result changed");

  // no request is accepted in the update cycle: the cycle after acceptance is stalled
  a_two_cycle: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted in update cycle");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evicted))
    else $error("hit and eviction together");

  // only non-zero handles are ever cached
  a_hit_handle: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> handle != '0)
    else $error("hit returned zero handle");

  // no eviction reports no evicted handle
  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted |-> evicted_handle == '0)
    else $error("evicted handle without eviction");

endmodule

bind lru_keyed_handle_cache_top lkhc_checker u_lkhc_checker (.*);
